// File: rtl/motion_session_fair_scheduler_core_defines.svh
// ----------------------------------------------------------------------------
// Motion session fair scheduler: assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef MOTION_SESSION_FAIR_SCHEDULER_CORE_DEFINES_SVH
`define MOTION_SESSION_FAIR_SCHEDULER_CORE_DEFINES_SVH

// same-cycle implication
`define MSFS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MSFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/msfs_pkg.sv
// ----------------------------------------------------------------------------
// Motion session fair scheduler: package
// Types, codes and constants shared by controller and datapath.
// ----------------------------------------------------------------------------
package msfs_pkg;

	localparam int NUM_CAMERAS = 16;
	localparam int CAM_W       = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;

	localparam logic [31:0] GAP_RST   = 32'd10000;
	localparam logic [15:0] ALPHA_RST = 16'd19661;
	localparam logic [40:0] RATE_RST  = 41'd1099511;
	localparam logic [40:0] RATE_FLOOR = 41'd12726;

	localparam int DIV_NW = 57;
	localparam int DIV_DW = 48;

	typedef enum logic [1:0] {
		REQ_MOTION = 2'd0,
		REQ_TICK   = 2'd1,
		REQ_SERVE  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		CFG_GAP   = 2'd0,
		CFG_ALPHA = 2'd1,
		CFG_RATE  = 2'd2,
		CFG_NONE  = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOT,
		ST_CLOSE,
		ST_DIV,
		ST_EMA_MUL,
		ST_EMA_SUM,
		ST_CLOSE_FIN,
		ST_NEW,
		ST_TICK,
		ST_SRV_SCAN,
		ST_SRV_PICK,
		ST_SRV_WAIT
	} state_t;

	typedef enum logic [1:0] {
		RET_IDLE,
		RET_NEW,
		RET_TICK
	} ret_t;

	typedef struct packed {
		logic [47:0] start_ms;
		logic [47:0] last_ms;
		logic [31:0] tag;
		logic [15:0] fw;
		logic [15:0] fh;
		logic [15:0] bx;
		logic [15:0] by;
		logic [15:0] bw;
		logic [15:0] bh;
	} sess_t;

	typedef struct packed {
		logic        latch;
		logic        idx_cam;
		logic        idx_clear;
		logic        idx_inc;
		logic        extend;
		logic        start_new;
		logic        div_start;
		logic        div_srv;
		logic        ema_mul;
		logic        ema_write;
		logic        close_commit;
		logic        srv_clear;
		logic        srv_cmp;
		logic        srv_commit;
		logic        srv_none;
	} cmd_t;

	typedef struct packed {
		logic cam_ok;
		logic is_end;
		logic open_valid;
		logic extend_ok;
		logic tick_close;
		logic rate_upd;
		logic div_done;
		logic idx_last;
		logic best_found;
	} sts_t;

endpackage

// File: rtl/msfs_div.sv
// ----------------------------------------------------------------------------
// Motion session fair scheduler: serial divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msfs_div import msfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic              done,
	output logic [DIV_NW-1:0] quo
);

	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;
	logic [DIV_DW:0]   rem_sh;
	logic              ge;

	assign rem_sh = {rem_q, quo_q[DIV_NW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? DIV_DW'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: rtl/msfs_datapath.sv
// ----------------------------------------------------------------------------
// Motion session fair scheduler: datapath
// Camera table, configuration, item latch, rate and virtual time arithmetic.
// ----------------------------------------------------------------------------
module msfs_datapath import msfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [40:0] cfg_data,
	input  logic [3:0]  camera,
	input  logic        is_end,
	input  logic [47:0] time_ms,
	input  logic [31:0] frame_tag,
	input  logic [15:0] frame_width,
	input  logic [15:0] frame_height,
	input  logic [15:0] box_x,
	input  logic [15:0] box_y,
	input  logic [15:0] box_width,
	input  logic [15:0] box_height,
	output logic        done,
	output logic        found,
	output logic [3:0]  served_camera,
	output logic [47:0] start_ms,
	output logic [47:0] last_ms,
	output logic [31:0] best_frame_tag,
	output logic [15:0] best_img_width,
	output logic [15:0] best_img_height,
	output logic [15:0] best_box_x,
	output logic [15:0] best_box_y,
	output logic [15:0] best_box_width,
	output logic [15:0] best_box_height
);

	logic [31:0] gap_q;
	logic [15:0] alpha_q;

	logic [NUM_CAMERAS-1:0] open_valid_q;
	logic [NUM_CAMERAS-1:0] pend_valid_q;
	sess_t                  open_rec_q [NUM_CAMERAS];
	sess_t                  pend_rec_q [NUM_CAMERAS];
	logic [31:0]            area_q     [NUM_CAMERAS];
	logic [40:0]            rate_q     [NUM_CAMERAS];
	logic [63:0]            vt_q       [NUM_CAMERAS];
	logic [47:0]            last_end_q [NUM_CAMERAS];

	sess_t            item_q;
	logic [3:0]       cam_q;
	logic             end_q;
	logic [CAM_W-1:0] idx_q;
	logic [CAM_W-1:0] best_q;
	logic             best_ok_q;
	logic [56:0]      p1_q;
	logic [57:0]      p2_q;

	sess_t       cur;
	logic [31:0] area;
	logic [47:0] gap48;
	logic [47:0] last_end;
	logic [40:0] rate_sel;
	logic [40:0] rate_ld;
	logic [56:0] div_num;
	logic [47:0] div_den;
	logic        div_done;
	logic [56:0] quo;
	logic [58:0] ema_sum;
	logic [42:0] ema;
	logic [64:0] vt_sum;

	assign cur      = open_rec_q[idx_q];
	assign area     = item_q.bw * item_q.bh;
	assign gap48    = {16'd0, gap_q};
	assign last_end = last_end_q[idx_q];
	assign rate_sel = (rate_q[best_q] == '0) ? 41'd1 : rate_q[best_q];
	assign rate_ld  = (cfg_data == '0) ? 41'd1 : cfg_data;

	assign div_num = cmd.div_srv ? (57'd1 << 56) : (57'd1 << 40);
	assign div_den = cmd.div_srv ? {7'd0, rate_sel} : (cur.start_ms - last_end);

	msfs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	assign ema_sum = 59'(p1_q) + 59'(p2_q) + 59'd32768;
	assign ema     = ema_sum[58:16];
	assign vt_sum  = {1'b0, vt_q[best_q]} + 65'(quo);

	always_comb begin
		sts.cam_ok     = 32'(cam_q) < NUM_CAMERAS;
		sts.is_end     = end_q;
		sts.open_valid = open_valid_q[idx_q];
		sts.extend_ok  = (item_q.start_ms <= cur.last_ms) ||
		                 ((item_q.start_ms - cur.last_ms) <= gap48);
		sts.tick_close = open_valid_q[idx_q] && (item_q.start_ms >= cur.last_ms) &&
		                 ((item_q.start_ms - cur.last_ms) >= gap48);
		sts.rate_upd   = (last_end != '0) && (cur.start_ms > last_end);
		sts.div_done   = div_done;
		sts.idx_last   = idx_q == CAM_W'(NUM_CAMERAS - 1);
		sts.best_found = best_ok_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q        <= GAP_RST;
			alpha_q      <= ALPHA_RST;
			open_valid_q <= '0;
			pend_valid_q <= '0;
			idx_q        <= '0;
			best_ok_q    <= 1'b0;
			done         <= 1'b0;
			for (int i = 0; i < NUM_CAMERAS; i++) begin
				rate_q[i]     <= RATE_RST;
				vt_q[i]       <= '0;
				last_end_q[i] <= '0;
			end
		end else begin
			done <= cmd.srv_commit | cmd.srv_none;
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_GAP:   gap_q   <= cfg_data[31:0];
					CFG_ALPHA: alpha_q <= cfg_data[15:0];
					CFG_RATE: begin
						for (int i = 0; i < NUM_CAMERAS; i++)
							rate_q[i] <= rate_ld;
					end
					default: ;
				endcase
			end
			if (cmd.idx_cam)
				idx_q <= camera[CAM_W-1:0];
			else if (cmd.idx_clear)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + 1'b1;
			if (cmd.start_new)
				open_valid_q[idx_q] <= 1'b1;
			if (cmd.ema_write)
				rate_q[idx_q] <= (ema < 43'(RATE_FLOOR)) ? RATE_FLOOR : ema[40:0];
			if (cmd.close_commit) begin
				open_valid_q[idx_q] <= 1'b0;
				last_end_q[idx_q]   <= cur.last_ms;
				pend_valid_q[idx_q] <= 1'b1;
			end
			if (cmd.srv_clear)
				best_ok_q <= 1'b0;
			if (cmd.srv_cmp && pend_valid_q[idx_q] &&
			    (!best_ok_q || (vt_q[idx_q] < vt_q[best_q])))
				best_ok_q <= 1'b1;
			if (cmd.srv_commit) begin
				pend_valid_q[best_q] <= 1'b0;
				vt_q[best_q]         <= vt_sum[64] ? '1 : vt_sum[63:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= '{time_ms, time_ms, frame_tag, frame_width, frame_height,
			            box_x, box_y, box_width, box_height};
			cam_q  <= camera;
			end_q  <= is_end;
		end
		if (cmd.extend) begin
			if (area > area_q[idx_q]) begin
				open_rec_q[idx_q] <= '{cur.start_ms, item_q.start_ms, item_q.tag,
				                       item_q.fw, item_q.fh, item_q.bx, item_q.by,
				                       item_q.bw, item_q.bh};
				area_q[idx_q]     <= area;
			end else begin
				open_rec_q[idx_q].last_ms <= item_q.start_ms;
			end
		end
		if (cmd.start_new) begin
			open_rec_q[idx_q] <= item_q;
			area_q[idx_q]     <= area;
		end
		if (cmd.close_commit && !pend_valid_q[idx_q])
			pend_rec_q[idx_q] <= cur;
		if (cmd.ema_mul) begin
			p1_q <= alpha_q * quo[40:0];
			p2_q <= (17'd65536 - {1'b0, alpha_q}) * rate_q[idx_q];
		end
		if (cmd.srv_cmp && pend_valid_q[idx_q] &&
		    (!best_ok_q || (vt_q[idx_q] < vt_q[best_q])))
			best_q <= idx_q;
		if (cmd.srv_commit) begin
			found           <= 1'b1;
			served_camera   <= 4'(best_q);
			start_ms        <= pend_rec_q[best_q].start_ms;
			last_ms         <= pend_rec_q[best_q].last_ms;
			best_frame_tag  <= pend_rec_q[best_q].tag;
			best_img_width  <= pend_rec_q[best_q].fw;
			best_img_height <= pend_rec_q[best_q].fh;
			best_box_x      <= pend_rec_q[best_q].bx;
			best_box_y      <= pend_rec_q[best_q].by;
			best_box_width  <= pend_rec_q[best_q].bw;
			best_box_height <= pend_rec_q[best_q].bh;
		end else if (cmd.srv_none) begin
			found           <= 1'b0;
			served_camera   <= '0;
			start_ms        <= '0;
			last_ms         <= '0;
			best_frame_tag  <= '0;
			best_img_width  <= '0;
			best_img_height <= '0;
			best_box_x      <= '0;
			best_box_y      <= '0;
			best_box_width  <= '0;
			best_box_height <= '0;
		end
	end

endmodule

// File: rtl/msfs_ctrl.sv
// ----------------------------------------------------------------------------
// Motion session fair scheduler: controller
// Sequences motion, tick and service requests over the datapath.
// ----------------------------------------------------------------------------
module msfs_ctrl import msfs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] req_type,
	input  sts_t       sts,
	output cmd_t       cmd,
	output logic       busy
);

	state_t state_q, state_d;
	ret_t   ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= RET_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	assign busy = state_q != ST_IDLE;

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					unique case (req_t'(req_type))
						REQ_MOTION: begin
							cmd.idx_cam = 1'b1;
							state_d     = ST_MOT;
						end
						REQ_TICK: begin
							cmd.idx_clear = 1'b1;
							state_d       = ST_TICK;
						end
						REQ_SERVE: begin
							cmd.idx_clear = 1'b1;
							cmd.srv_clear = 1'b1;
							state_d       = ST_SRV_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_MOT: begin
				state_d = ST_IDLE;
				if (sts.cam_ok) begin
					if (sts.open_valid) begin
						if (sts.extend_ok) begin
							cmd.extend = 1'b1;
							if (sts.is_end) begin
								ret_d   = RET_IDLE;
								state_d = ST_CLOSE;
							end
						end else begin
							ret_d   = RET_NEW;
							state_d = ST_CLOSE;
						end
					end else if (!sts.is_end) begin
						cmd.start_new = 1'b1;
					end
				end
			end
			ST_CLOSE: begin
				if (sts.rate_upd) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = ST_CLOSE_FIN;
				end
			end
			ST_DIV: begin
				if (sts.div_done)
					state_d = ST_EMA_MUL;
			end
			ST_EMA_MUL: begin
				cmd.ema_mul = 1'b1;
				state_d     = ST_EMA_SUM;
			end
			ST_EMA_SUM: begin
				cmd.ema_write = 1'b1;
				state_d       = ST_CLOSE_FIN;
			end
			ST_CLOSE_FIN: begin
				cmd.close_commit = 1'b1;
				unique case (ret_q)
					RET_NEW:  state_d = ST_NEW;
					RET_TICK: begin
						if (sts.idx_last) begin
							state_d = ST_IDLE;
						end else begin
							cmd.idx_inc = 1'b1;
							state_d     = ST_TICK;
						end
					end
					default:  state_d = ST_IDLE;
				endcase
			end
			ST_NEW: begin
				cmd.start_new = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_TICK: begin
				if (sts.tick_close) begin
					ret_d   = RET_TICK;
					state_d = ST_CLOSE;
				end else if (sts.idx_last) begin
					state_d = ST_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_SRV_SCAN: begin
				cmd.srv_cmp = 1'b1;
				if (sts.idx_last)
					state_d = ST_SRV_PICK;
				else
					cmd.idx_inc = 1'b1;
			end
			ST_SRV_PICK: begin
				if (sts.best_found) begin
					cmd.div_start = 1'b1;
					cmd.div_srv   = 1'b1;
					state_d       = ST_SRV_WAIT;
				end else begin
					cmd.srv_none = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_SRV_WAIT: begin
				if (sts.div_done) begin
					cmd.srv_commit = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: rtl/motion_session_fair_scheduler_core.sv
// ----------------------------------------------------------------------------
// Motion session fair scheduler core
// Per-camera motion sessions, EMA session rate and virtual-time service.
//
// channel   signals                                   handshake
// request   req_type camera is_end time_ms frame/box  start & !busy
// result    found served_camera start_ms ... box_h    done, one cycle
// config    cfg_index cfg_data                        cfg_we
//
// Motion: takes longer when a session closes with a rate update.
// Tick: scans every camera and closes each expired session.
// Service: scan of all cameras, then the 57-bit serial reciprocal; done
// is registered once the reciprocal completes. The serial divider is shared.
// Reset clears all control state at once; results cannot be stalled.
// ----------------------------------------------------------------------------
`include "motion_session_fair_scheduler_core_defines.svh"

module motion_session_fair_scheduler_core import msfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [3:0]  camera,
	input  logic        is_end,
	input  logic [47:0] time_ms,
	input  logic [31:0] frame_tag,
	input  logic [15:0] frame_width,
	input  logic [15:0] frame_height,
	input  logic [15:0] box_x,
	input  logic [15:0] box_y,
	input  logic [15:0] box_width,
	input  logic [15:0] box_height,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [40:0] cfg_data,
	output logic        done,
	output logic        found,
	output logic [3:0]  served_camera,
	output logic [47:0] start_ms,
	output logic [47:0] last_ms,
	output logic [31:0] best_frame_tag,
	output logic [15:0] best_img_width,
	output logic [15:0] best_img_height,
	output logic [15:0] best_box_x,
	output logic [15:0] best_box_y,
	output logic [15:0] best_box_width,
	output logic [15:0] best_box_height
);

	cmd_t cmd;
	sts_t sts;

	msfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	msfs_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.camera          (camera),
		.is_end          (is_end),
		.time_ms         (time_ms),
		.frame_tag       (frame_tag),
		.frame_width     (frame_width),
		.frame_height    (frame_height),
		.box_x           (box_x),
		.box_y           (box_y),
		.box_width       (box_width),
		.box_height      (box_height),
		.done            (done),
		.found           (found),
		.served_camera   (served_camera),
		.start_ms        (start_ms),
		.last_ms         (last_ms),
		.best_frame_tag  (best_frame_tag),
		.best_img_width  (best_img_width),
		.best_img_height (best_img_height),
		.best_box_x      (best_box_x),
		.best_box_y      (best_box_y),
		.best_box_width  (best_box_width),
		.best_box_height (best_box_height)
	);

	`MSFS_ASSERT_NOW(a_done_after_busy, done, $past(busy), "result without a request in flight")
	`MSFS_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
	`MSFS_ASSERT_NEXT(a_serve_busy, start && !busy && req_type == REQ_SERVE, busy, "service request not taken")

endmodule
